[rtl/core/rpc_pkg.sv]
// Shared constants, codes and types of the rook placement counter.
package rpc_pkg;

    localparam int DEFAULT_MAX_COLS = 12;
    localparam int MASK_W           = 12;
    localparam int CFG_W            = 4;
    localparam int COUNT_W          = 64;
    localparam int CFG_IDX_W        = 1;

    localparam logic [CFG_W-1:0] COL_COUNT_RESET  = 4'd12;
    localparam logic [CFG_W-1:0] ROOK_COUNT_RESET = 4'd1;

    typedef logic [COUNT_W-1:0] count_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COL_COUNT  = 1'b0,
        CFG_ROOK_COUNT = 1'b1
    } cfg_index_t;

    // Top-level sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE,
        ST_WAIT,
        ST_SWEEP
    } state_t;

    // Control handed to the sum-and-clear sweep.
    typedef struct packed {
        logic start;
        logic sum_en;
    } sweep_ctrl_t;

endpackage

[rtl/core/rpc_row_if.sv]
// Request channel that carries one board row.
interface rpc_row_if;
    import rpc_pkg::*;

    logic              valid;
    logic              ready;
    logic [MASK_W-1:0] blocked_mask;
    logic              last_row;

    modport source (output valid, output blocked_mask, output last_row, input ready);
    modport sink   (input valid, input blocked_mask, input last_row, output ready);
endinterface

[rtl/core/rpc_count_if.sv]
// Result channel that carries one placement count.
interface rpc_count_if;
    import rpc_pkg::*;

    logic   valid;
    logic   ready;
    count_t placement_count;

    modport source (output valid, output placement_count, input ready);
    modport sink   (input valid, input placement_count, output ready);
endinterface

[rtl/core/rpc_table_ram.sv]
// Count table memory: one write port and one registered read port.
module rpc_table_ram #(
    parameter int ADDR_W = rpc_pkg::DEFAULT_MAX_COLS
) (
    input  logic                clk,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    output rpc_pkg::count_t     rd_data,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  rpc_pkg::count_t     wr_data
);
    import rpc_pkg::*;

    count_t mem [2**ADDR_W];

    // A read of the entry written in the same cycle returns the old contents.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

[rtl/core/rpc_row_update.sv]
// Row update: walks the column sets downward and adds each set's free predecessors.
module rpc_row_update #(
    parameter  int MAX_COLS = rpc_pkg::DEFAULT_MAX_COLS,
    localparam int CNT_W    = $clog2(MAX_COLS + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [CNT_W-1:0]     col_limit,
    input  logic [MAX_COLS-1:0]  free_cols,
    output logic                 rd_en,
    output logic [MAX_COLS-1:0]  rd_addr,
    input  rpc_pkg::count_t      rd_data,
    output logic                 wr_en,
    output logic [MAX_COLS-1:0]  wr_addr,
    output rpc_pkg::count_t      wr_data,
    output logic                 done
);
    import rpc_pkg::*;

    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    logic                run_reg;
    logic [MAX_COLS-1:0] set_reg;
    logic [CNT_W-1:0]    step_reg;
    logic                d_valid_reg;
    logic                d_first_reg;
    logic                d_last_reg;
    logic                d_use_reg;
    logic [MAX_COLS-1:0] d_set_reg;
    count_t              acc_reg;
    count_t              acc_next;
    logic [COL_W-1:0]    col;
    logic                use_pred;
    logic                last_step;

    // Step zero reads the set itself; step c+1 reads the set without column c.
    always_comb
    begin
        col       = COL_W'(step_reg - CNT_W'(1));
        last_step = (step_reg == CNT_W'(MAX_COLS));
        use_pred  = (step_reg != '0) && set_reg[col] && free_cols[col];
        rd_en     = run_reg;
        if (step_reg == '0)
        begin
            rd_addr = set_reg;
        end
        else
        begin
            rd_addr = set_reg ^ (MAX_COLS'(1) << col);
        end
    end

    // Set and step counters; sets go downward so predecessors are still old.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg     <= 1'b0;
            set_reg     <= '0;
            step_reg    <= '0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            d_valid_reg <= run_reg;
            if (start)
            begin
                run_reg  <= 1'b1;
                set_reg  <= ~({MAX_COLS{1'b1}} << col_limit);
                step_reg <= '0;
            end
            else if (run_reg)
            begin
                if (last_step)
                begin
                    step_reg <= '0;
                    if (set_reg == '0)
                    begin
                        run_reg <= 1'b0;
                    end
                    else
                    begin
                        set_reg <= set_reg - MAX_COLS'(1);
                    end
                end
                else
                begin
                    step_reg <= step_reg + CNT_W'(1);
                end
            end
        end
    end

    // Read tags travel alongside the registered memory read.
    always_ff @(posedge clk)
    begin
        d_first_reg <= (step_reg == '0);
        d_last_reg  <= last_step;
        d_use_reg   <= use_pred;
        d_set_reg   <= set_reg;
        if (d_valid_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    // Accumulate the set's old count and its predecessors, then write back.
    always_comb
    begin
        if (d_first_reg)
        begin
            acc_next = rd_data;
        end
        else if (d_use_reg)
        begin
            acc_next = acc_reg + rd_data;
        end
        else
        begin
            acc_next = acc_reg;
        end
        wr_en   = d_valid_reg && d_last_reg;
        wr_addr = d_set_reg;
        wr_data = acc_next;
        done    = d_valid_reg && d_last_reg && (d_set_reg == '0);
    end
endmodule

[rtl/core/rpc_sum_clear.sv]
// Sweep over the whole table: sums sets of the chosen size and restores the start contents.
module rpc_sum_clear #(
    parameter  int MAX_COLS = rpc_pkg::DEFAULT_MAX_COLS,
    localparam int CNT_W    = $clog2(MAX_COLS + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rpc_pkg::sweep_ctrl_t  ctrl,
    input  logic [CNT_W-1:0]      col_limit,
    input  logic [rpc_pkg::CFG_W-1:0] rook_limit,
    output logic                  rd_en,
    output logic [MAX_COLS-1:0]   rd_addr,
    input  rpc_pkg::count_t       rd_data,
    output logic                  wr_en,
    output logic [MAX_COLS-1:0]   wr_addr,
    output rpc_pkg::count_t       wr_data,
    output rpc_pkg::count_t       sum,
    output logic                  done
);
    import rpc_pkg::*;

    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    logic                run_reg;
    logic [MAX_COLS-1:0] addr_reg;
    logic                sum_en_reg;
    logic                d_valid_reg;
    logic [MAX_COLS-1:0] d_addr_reg;
    logic                done_reg;
    count_t              sum_reg;
    logic [CNT_W-1:0]    ones;
    logic                hit;

    // Each entry is read and overwritten in the same cycle.
    always_comb
    begin
        rd_en   = run_reg;
        rd_addr = addr_reg;
        wr_en   = run_reg;
        wr_addr = addr_reg;
        wr_data = (addr_reg == '0) ? COUNT_W'(1) : '0;
    end

    // Column count of the returning set and whether it is counted.
    always_comb
    begin
        ones = '0;
        for (int i = 0; i < MAX_COLS; i++)
        begin
            ones = ones + CNT_W'(d_addr_reg[i]);
        end
        hit = sum_en_reg && ((d_addr_reg >> col_limit) == '0)
              && (CMP_W'(ones) == CMP_W'(rook_limit));
    end

    // Sweep counter; it also runs once out of reset to initialize the table.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg     <= 1'b1;
            addr_reg    <= '0;
            sum_en_reg  <= 1'b0;
            d_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            d_valid_reg <= run_reg;
            done_reg    <= d_valid_reg && (d_addr_reg == '1);
            if (ctrl.start)
            begin
                run_reg    <= 1'b1;
                addr_reg   <= '0;
                sum_en_reg <= ctrl.sum_en;
            end
            else if (run_reg)
            begin
                addr_reg <= addr_reg + MAX_COLS'(1);
                if (addr_reg == '1)
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    // Running sum of the old contents.
    always_ff @(posedge clk)
    begin
        d_addr_reg <= addr_reg;
        if (ctrl.start)
        begin
            sum_reg <= '0;
        end
        else if (d_valid_reg && hit)
        begin
            sum_reg <= sum_reg + rd_data;
        end
    end

    assign sum  = sum_reg;
    assign done = done_reg;
endmodule

[rtl/core/rook_placement_counter.sv]
// Rook placement counter: one row per request, one count per board after the last row.
// A row reads each of its 2^m column sets MAX_COLS + 1 times, m the columns in use: one table read per cycle.
// A last row adds a sweep over all 2^MAX_COLS entries that sums and re-initializes the table.
// Rows are taken one at a time; a finished count waits in an output register meanwhile.
// After reset the table is initialized by a pass over every entry; no row is taken until then.
module rook_placement_counter #(
    parameter int MAX_COLS = rpc_pkg::DEFAULT_MAX_COLS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    rpc_row_if.sink                      row,
    rpc_count_if.source                  result,
    input  logic                         cfg_en,
    input  rpc_pkg::cfg_index_t          cfg_index,
    input  logic [rpc_pkg::CFG_W-1:0]    cfg_data
);
    import rpc_pkg::*;

    localparam int CNT_W = $clog2(MAX_COLS + 1);
    localparam int EXT_W = MAX_COLS + MASK_W;

    state_t              state_reg;
    state_t              state_next;
    logic [CFG_W-1:0]    col_count_reg;
    logic [CFG_W-1:0]    rook_count_reg;
    logic [CNT_W-1:0]    col_limit_reg;
    logic [CFG_W-1:0]    rook_limit_reg;
    logic [MAX_COLS-1:0] free_reg;
    logic [MAX_COLS-1:0] free_next;
    logic [CNT_W-1:0]    col_limit_next;
    logic                last_reg;
    logic                upd_start_reg;
    logic                res_valid_reg;
    count_t              res_count_reg;
    logic [EXT_W-1:0]    blocked_ext;
    logic                row_accept;
    logic                sweep_done_ack;
    sweep_ctrl_t         sweep_ctrl;

    logic                upd_rd_en;
    logic [MAX_COLS-1:0] upd_rd_addr;
    logic                upd_wr_en;
    logic [MAX_COLS-1:0] upd_wr_addr;
    count_t              upd_wr_data;
    logic                upd_done;
    logic                swp_rd_en;
    logic [MAX_COLS-1:0] swp_rd_addr;
    logic                swp_wr_en;
    logic [MAX_COLS-1:0] swp_wr_addr;
    count_t              swp_wr_data;
    count_t              swp_sum;
    logic                swp_done;
    logic                mem_rd_en;
    logic [MAX_COLS-1:0] mem_rd_addr;
    count_t              mem_rd_data;
    logic                mem_wr_en;
    logic [MAX_COLS-1:0] mem_wr_addr;
    count_t              mem_wr_data;

    assign row.ready       = (state_reg == ST_IDLE);
    assign row_accept      = row.valid && row.ready;
    assign result.valid    = res_valid_reg;
    assign result.placement_count = res_count_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg  <= COL_COUNT_RESET;
            rook_count_reg <= ROOK_COUNT_RESET;
        end
        else if (cfg_en)
        begin
            unique case (cfg_index)
                CFG_COL_COUNT:  col_count_reg  <= cfg_data;
                CFG_ROOK_COUNT: rook_count_reg <= cfg_data;
                default:        col_count_reg  <= col_count_reg;
            endcase
        end
    end

    // Columns in use and the free columns of the incoming row.
    always_comb
    begin
        if (32'(col_count_reg) > MAX_COLS)
        begin
            col_limit_next = CNT_W'(MAX_COLS);
        end
        else
        begin
            col_limit_next = CNT_W'(col_count_reg);
        end
        blocked_ext = EXT_W'(row.blocked_mask);
        for (int c = 0; c < MAX_COLS; c++)
        begin
            free_next[c] = (32'(col_limit_next) > c) && !blocked_ext[c];
        end
    end

    // Row settings held for the length of the row.
    always_ff @(posedge clk)
    begin
        if (row_accept)
        begin
            col_limit_reg  <= col_limit_next;
            rook_limit_reg <= rook_count_reg;
            free_reg       <= free_next;
            last_reg       <= row.last_row;
        end
    end

    // Sequencer: next state and sweep control.
    always_comb
    begin
        state_next        = state_reg;
        sweep_ctrl.start  = 1'b0;
        sweep_ctrl.sum_en = 1'b1;
        sweep_done_ack    = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (swp_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (row_accept)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (upd_done)
                begin
                    if (!last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (res_valid_reg && !result.ready)
                    begin
                        state_next = ST_WAIT;
                    end
                    else
                    begin
                        state_next       = ST_SWEEP;
                        sweep_ctrl.start = 1'b1;
                    end
                end
            end
            ST_WAIT:
            begin
                if (!res_valid_reg || result.ready)
                begin
                    state_next       = ST_SWEEP;
                    sweep_ctrl.start = 1'b1;
                end
            end
            ST_SWEEP:
            begin
                if (swp_done)
                begin
                    state_next     = ST_IDLE;
                    sweep_done_ack = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // State register, update start and output register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            upd_start_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            upd_start_reg <= row_accept;
            if (sweep_done_ack)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Count payload of the output register.
    always_ff @(posedge clk)
    begin
        if (sweep_done_ack)
        begin
            res_count_reg <= swp_sum;
        end
    end

    // The row update owns the table while it runs; the sweep owns it otherwise.
    always_comb
    begin
        if (state_reg == ST_UPDATE)
        begin
            mem_rd_en   = upd_rd_en;
            mem_rd_addr = upd_rd_addr;
            mem_wr_en   = upd_wr_en;
            mem_wr_addr = upd_wr_addr;
            mem_wr_data = upd_wr_data;
        end
        else
        begin
            mem_rd_en   = swp_rd_en;
            mem_rd_addr = swp_rd_addr;
            mem_wr_en   = swp_wr_en;
            mem_wr_addr = swp_wr_addr;
            mem_wr_data = swp_wr_data;
        end
    end

    rpc_table_ram #(
        .ADDR_W (MAX_COLS)
    ) u_table (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    rpc_row_update #(
        .MAX_COLS (MAX_COLS)
    ) u_update (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (upd_start_reg),
        .col_limit (col_limit_reg),
        .free_cols (free_reg),
        .rd_en     (upd_rd_en),
        .rd_addr   (upd_rd_addr),
        .rd_data   (mem_rd_data),
        .wr_en     (upd_wr_en),
        .wr_addr   (upd_wr_addr),
        .wr_data   (upd_wr_data),
        .done      (upd_done)
    );

    rpc_sum_clear #(
        .MAX_COLS (MAX_COLS)
    ) u_sweep (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (sweep_ctrl),
        .col_limit  (col_limit_reg),
        .rook_limit (rook_limit_reg),
        .rd_en      (swp_rd_en),
        .rd_addr    (swp_rd_addr),
        .rd_data    (mem_rd_data),
        .wr_en      (swp_wr_en),
        .wr_addr    (swp_wr_addr),
        .wr_data    (swp_wr_data),
        .sum        (swp_sum),
        .done       (swp_done)
    );
endmodule

[tb/rook_placement_counter_tb.sv]
// Self-checking testbench of the rook placement counter: board rows in, placement counts out.
module rook_placement_counter_tb;
    import rpc_pkg::*;

    localparam int TABLE_DEPTH   = 1 << DEFAULT_MAX_COLS;
    // Sum-and-clear sweep after a last row, with some margin.
    localparam int SETTLE_CYCLES = 4200;
    // Cycles without any taken row or count before the run is declared hung.
    localparam int STALL_LIMIT   = 300000;
    localparam int RANDOM_ROWS   = 76;

    typedef struct packed {
        logic [MASK_W-1:0] blocked;
        logic              last_row;
    } board_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Signals driven into the block, known from time zero.
    logic              row_valid   = 1'b0;
    logic [MASK_W-1:0] row_mask    = '0;
    logic              row_last    = 1'b0;
    logic              count_ready = 1'b0;
    logic              cfg_en      = 1'b0;
    cfg_index_t        cfg_index   = CFG_COL_COUNT;
    logic [CFG_W-1:0]  cfg_data    = '0;

    // Row requests waiting to be sent and counts still owed by the block.
    board_row_t rows_to_send[$];
    count_t     pending_counts[$];

    // Own copy of the placement table and of the registers.
    count_t           placements_by_cols [0:TABLE_DEPTH-1];
    count_t           placements_prev    [0:TABLE_DEPTH-1];
    logic [CFG_W-1:0] col_setting  = COL_COUNT_RESET;
    logic [CFG_W-1:0] rook_setting = ROOK_COUNT_RESET;

    logic row_taken    = 1'b0;
    logic steady       = 1'b0;
    int   error_count  = 0;
    int   stall_cycles = 0;

    rpc_row_if   row_bus ();
    rpc_count_if count_bus ();

    assign row_bus.valid        = row_valid;
    assign row_bus.blocked_mask = row_mask;
    assign row_bus.last_row     = row_last;
    assign count_bus.ready      = count_ready;

    rook_placement_counter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .row       (row_bus),
        .result    (count_bus),
        .cfg_en    (cfg_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Empty board: one placement of no rooks, nothing else.
    task automatic restart_table();
        foreach (placements_by_cols[i])
        begin
            placements_by_cols[i] = '0;
        end
        placements_by_cols[0] = 64'd1;
    endtask

    // Advance the table by one row; on the last row owe the count and start over.
    task automatic take_row(input logic [MASK_W-1:0] blocked, input logic last_row);
        int unsigned m;
        int unsigned n_sets;
        int unsigned s;
        int          c;
        count_t      total;
        m      = (col_setting > DEFAULT_MAX_COLS) ? DEFAULT_MAX_COLS : int'(col_setting);
        n_sets = 1 << m;
        placements_prev = placements_by_cols;
        for (s = 0; s < n_sets; s++)
        begin
            for (c = 0; c < int'(m); c++)
            begin
                if (!blocked[c] && !s[c])
                begin
                    placements_by_cols[s | (1 << c)] += placements_prev[s];
                end
            end
        end
        if (last_row)
        begin
            total = '0;
            for (s = 0; s < n_sets; s++)
            begin
                if ($countones(s) == int'(rook_setting))
                begin
                    total += placements_by_cols[s];
                end
            end
            pending_counts.push_back(total);
            restart_table();
        end
    endtask

    task automatic queue_row(input logic [MASK_W-1:0] blocked, input logic last_row);
        board_row_t item;
        item.blocked  = blocked;
        item.last_row = last_row;
        rows_to_send.push_back(item);
    endtask

    // Hold the sender until every queued row is gone and every count has come back.
    task automatic wait_for_drain();
        do
        begin
            @(negedge clk);
        end
        while (rows_to_send.size() != 0 || row_valid || pending_counts.size() != 0);
        @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_en    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == CFG_COL_COUNT)
        begin
            col_setting = value;
        end
        else
        begin
            rook_setting = value;
        end
        @(negedge clk);
        cfg_en <= 1'b0;
    endtask

    // New settings only once the block is idle, past its clearing sweep.
    task automatic start_phase(input logic [CFG_W-1:0] cols, input logic [CFG_W-1:0] rooks);
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(CFG_COL_COUNT, cols);
        write_reg(CFG_ROOK_COUNT, rooks);
        @(posedge clk);
    endtask

    // Row driver: holds a request until it is taken, otherwise idles now and then.
    always @(negedge clk)
    begin : drive_rows
        board_row_t item;
        if (!rst_n)
        begin
            row_valid <= 1'b0;
        end
        else if (!row_valid || row_taken)
        begin
            if (rows_to_send.size() != 0 && (steady || $urandom_range(0, 99) >= 24))
            begin
                item = rows_to_send.pop_front();
                row_valid <= 1'b1;
                row_mask  <= item.blocked;
                row_last  <= item.last_row;
            end
            else
            begin
                row_valid <= 1'b0;
            end
        end
    end

    // Count receiver stalls at random.
    always @(negedge clk)
    begin
        count_ready <= rst_n && (steady || $urandom_range(0, 99) >= 24);
    end

    // Monitor: check counts, feed taken rows to the predictor, watch for a hang.
    always @(posedge clk)
    begin : watch_bus
        count_t want;
        logic   count_taken;
        if (rst_n)
        begin
            row_taken   = row_valid && row_bus.ready;
            count_taken = count_bus.valid && count_ready;
            if (count_taken)
            begin
                if (pending_counts.size() == 0)
                begin
                    $display("%0t: placement_count expected none, got %0d",
                             $time, count_bus.placement_count);
                    error_count++;
                end
                else
                begin
                    want = pending_counts.pop_front();
                    if (count_bus.placement_count !== want)
                    begin
                        $display("%0t: placement_count expected %0d, got %0d",
                                 $time, want, count_bus.placement_count);
                        error_count++;
                    end
                end
            end
            if (row_taken)
            begin
                take_row(row_mask, row_last);
            end
            if (row_taken || count_taken)
            begin
                stall_cycles = 0;
            end
            else
            begin
                stall_cycles++;
            end
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("rook_placement_counter: mismatch");
                $finish;
            end
        end
    end

    // Stimulus: directed boards, then random boards under random settings.
    initial
    begin
        int               phase;
        int               boards;
        int               rows;
        int               max_rows;
        int               pick;
        int               random_rows;
        logic [CFG_W-1:0] cols;
        logic [CFG_W-1:0] rooks;
        logic [MASK_W-1:0] mask;

        restart_table();
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: all twelve columns, one rook.
        queue_row(12'h5A5, 1'b1);

        // Column count above the maximum saturates; two rooks on two rows.
        start_phase(4'd15, 4'd2);
        queue_row(12'h0F0, 1'b0);
        queue_row(12'h00F, 1'b1);

        // No columns: only the empty set, which counts for zero rooks.
        start_phase(4'd0, 4'd0);
        queue_row(12'hFFF, 1'b1);
        queue_row(12'h000, 1'b0);
        queue_row(12'h000, 1'b1);
        start_phase(4'd0, 4'd1);
        queue_row(12'h000, 1'b1);

        // More rooks than columns gives nothing.
        start_phase(4'd3, 4'd15);
        queue_row(12'h000, 1'b0);
        queue_row(12'h000, 1'b1);

        // Blocked bits above the columns in use are ignored.
        start_phase(4'd4, 4'd4);
        queue_row(12'hFF0, 1'b0);
        queue_row(12'hFF0, 1'b0);
        queue_row(12'hFF0, 1'b0);
        queue_row(12'hFF0, 1'b1);
        queue_row(12'h001, 1'b0);
        queue_row(12'h002, 1'b0);
        queue_row(12'h004, 1'b0);
        queue_row(12'h008, 1'b1);

        // Single column, blocked and free.
        start_phase(4'd1, 4'd1);
        queue_row(12'h001, 1'b1);
        queue_row(12'h000, 1'b0);
        queue_row(12'hFFE, 1'b1);

        start_phase(4'd6, 4'd3);
        queue_row(12'h000, 1'b0);
        queue_row(12'h02A, 1'b0);
        queue_row(12'h015, 1'b0);
        queue_row(12'hFC0, 1'b1);

        // Random boards; mostly narrow ones so that rows stay cheap.
        phase       = 0;
        random_rows = 0;
        while (random_rows < RANDOM_ROWS)
        begin
            pick = $urandom_range(0, 15);
            if (pick == 0)
            begin
                cols = 4'd0;
            end
            else if (pick <= 12)
            begin
                cols = 4'($urandom_range(1, 6));
            end
            else
            begin
                cols = 4'($urandom_range(7, 10));
            end
            if ($urandom_range(0, 7) == 0)
            begin
                rooks = 4'($urandom_range(0, 15));
            end
            else
            begin
                rooks = 4'($urandom_range(0, int'(cols)));
            end
            start_phase(cols, rooks);
            steady   = (phase == 2);
            boards   = steady ? 6 : $urandom_range(2, 4);
            max_rows = (cols > 6) ? 2 : 6;
            for (int b = 0; b < boards; b++)
            begin
                rows = $urandom_range(1, max_rows);
                for (int r = 0; r < rows; r++)
                begin
                    pick = $urandom_range(0, 9);
                    if (pick == 0)
                    begin
                        mask = '1;
                    end
                    else if (pick == 1)
                    begin
                        mask = '0;
                    end
                    else if (pick <= 3)
                    begin
                        mask = 12'($urandom_range(0, 4095));
                    end
                    else
                    begin
                        mask = 12'($urandom_range(0, 4095)) & 12'($urandom_range(0, 4095));
                    end
                    queue_row(mask, r == rows - 1);
                    random_rows++;
                end
                if ($urandom_range(0, 3) == 0)
                begin
                    wait_for_drain();
                end
            end
            phase++;
        end

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_counts.size() != 0)
        begin
            $display("%0t: placement_count expected %0d, got none",
                     $time, pending_counts[0]);
            error_count++;
        end
        if (error_count == 0)
        begin
            $display("rook_placement_counter: match");
        end
        else
        begin
            $display("rook_placement_counter: mismatch");
        end
        $finish;
    end

endmodule
